// File: sv/skyline_pivot_select_defines.svh
// ----------------------------------------------------------------------------
// skyline_pivot_select_defines
// Assertion macros for the skyline pivot selection RTL.
// ----------------------------------------------------------------------------
`ifndef SKYLINE_PIVOT_SELECT_DEFINES_SVH
`define SKYLINE_PIVOT_SELECT_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define SPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Types and constants for the skyline pivot selection block.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int MAX_POINTS = 64;
  localparam int NUM_ATTRS  = 8;
  localparam int VALUE_BITS = 32;
  localparam int SLOT_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int ID_W       = 16;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic [ID_W-1:0] point_id;
    logic signed [31:0] attr_0;
    logic signed [31:0] attr_1;
    logic signed [31:0] attr_2;
    logic signed [31:0] attr_3;
    logic signed [31:0] attr_4;
    logic signed [31:0] attr_5;
    logic signed [31:0] attr_6;
    logic signed [31:0] attr_7;
    logic last_point;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] survivor_id;
    logic is_pivot;
    logic [31:0] pivot_range;
    logic overflow;
    logic last_result;
  } out_item_t;

  typedef struct packed {
    logic  we;
    logic  re;
    slot_t addr;
    logic  head_ld_rd;
    logic  head_ld_cand;
    logic  cand_ld;
  } lane_ctrl_t;

  typedef struct packed {
    logic lt;   // head smaller than read value
    logic gt;   // head larger than read value
    logic cov;  // candidate not smaller than read value
  } lane_flag_t;

  typedef struct packed {
    logic   head_better;
    logic   cand_better;
    logic   covered;
    value_t mn;
    value_t mx;
  } merge_res_t;

endpackage

// File: sv/sps_lane.sv
// ----------------------------------------------------------------------------
// sps_lane
// One attribute lane: point store column, head and candidate registers,
// and the compares of this attribute.
// ----------------------------------------------------------------------------
module sps_lane (
  input  logic               clk_i,
  input  logic               en_i,
  input  sps_pkg::lane_ctrl_t ctrl_i,
  input  sps_pkg::value_t    wdata_i,
  output sps_pkg::value_t    rd_o,
  output sps_pkg::lane_flag_t flag_o
);
  import sps_pkg::*;

  value_t mem [MAX_POINTS];
  value_t rd_q;
  value_t head_q;
  value_t cand_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem[ctrl_i.addr] <= wdata_i;
    end
    if (ctrl_i.re) begin
      rd_q <= mem[ctrl_i.addr];
    end
    if (ctrl_i.head_ld_rd) begin
      head_q <= rd_q;
    end else if (ctrl_i.head_ld_cand) begin
      head_q <= cand_q;
    end
    if (ctrl_i.cand_ld) begin
      cand_q <= rd_q;
    end
  end

  assign rd_o       = rd_q;
  assign flag_o.lt  = en_i && (head_q < rd_q);
  assign flag_o.gt  = en_i && (head_q > rd_q);
  assign flag_o.cov = !en_i || (cand_q >= rd_q);

endmodule

// File: sv/sps_merge.sv
// ----------------------------------------------------------------------------
// sps_merge
// Combines the lane results: dominance flags, cover test, min and max of
// the enabled attributes.
// ----------------------------------------------------------------------------
module sps_merge (
  input  sps_pkg::value_t     rd_i   [sps_pkg::NUM_ATTRS],
  input  logic [sps_pkg::NUM_ATTRS-1:0] mask_i,
  input  sps_pkg::lane_flag_t flag_i [sps_pkg::NUM_ATTRS],
  output sps_pkg::merge_res_t res_o
);
  import sps_pkg::*;

  always_comb begin
    logic any;
    any = 1'b0;
    res_o.head_better = 1'b0;
    res_o.cand_better = 1'b0;
    res_o.covered     = 1'b1;
    res_o.mn          = '0;
    res_o.mx          = '0;
    for (int a = 0; a < NUM_ATTRS; a++) begin
      res_o.head_better = res_o.head_better | flag_i[a].lt;
      res_o.cand_better = res_o.cand_better | flag_i[a].gt;
      res_o.covered     = res_o.covered & flag_i[a].cov;
      if (mask_i[a]) begin
        if (!any) begin
          res_o.mn = rd_i[a];
          res_o.mx = rd_i[a];
          any      = 1'b1;
        end else if (rd_i[a] > res_o.mx) begin
          res_o.mx = rd_i[a];
        end else if (rd_i[a] < res_o.mn) begin
          res_o.mn = rd_i[a];
        end
      end
    end
  end

endmodule

// File: sv/skyline_pivot_select.sv
// ----------------------------------------------------------------------------
// skyline_pivot_select
// Loads a batch of points, selects a pivot over the enabled attribute
// subspace and streams out the surviving ids, pivot first.
// ----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  in        in   in_valid_i/in_ready_o   in_item_i  (sps_pkg::in_item_t)
//  out       out  out_valid_o/out_ready_i out_item_o (sps_pkg::out_item_t)
//  cfg       in   cfg_we_i                cfg_wdata_i (attribute mask)
//
//  A point that is not last is stored while there is room and the input
//  stays ready. The last point starts selection: the first head is fetched,
//  then each candidate visit goes through the lane stores, followed where the
//  decision needs it by a removal or by a cover scan over the earlier points;
//  each survivor is then emitted, held by output stalls. One batch
//  item is processed at a time. Reset clears control state only; the point
//  stores are written before they are read.
// ----------------------------------------------------------------------------
`include "skyline_pivot_select_defines.svh"

module skyline_pivot_select (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sps_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sps_pkg::out_item_t   out_item_o,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i
);
  import sps_pkg::*;

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_INIT_RD  = 5'd1;
  localparam logic [4:0] ST_INIT_CAP = 5'd2;
  localparam logic [4:0] ST_INIT_RNG = 5'd3;
  localparam logic [4:0] ST_LOOP     = 5'd4;
  localparam logic [4:0] ST_C_ORD    = 5'd5;
  localparam logic [4:0] ST_C_CMP    = 5'd6;
  localparam logic [4:0] ST_C_DEC    = 5'd7;
  localparam logic [4:0] ST_SC_CHK   = 5'd8;
  localparam logic [4:0] ST_SC_ORD   = 5'd9;
  localparam logic [4:0] ST_SC_CMP   = 5'd10;
  localparam logic [4:0] ST_RM_RD    = 5'd11;
  localparam logic [4:0] ST_RM_WR    = 5'd12;
  localparam logic [4:0] ST_E_ORD    = 5'd13;
  localparam logic [4:0] ST_E_ORD2   = 5'd14;
  localparam logic [4:0] ST_E_ID     = 5'd15;
  localparam logic [4:0] ST_E_WAIT   = 5'd16;

  logic [4:0]           state_q;
  logic [CNT_W-1:0]     count_q;
  logic                 ovf_q;
  logic [7:0]           mask_q;
  slot_t                tail_q;
  logic [CNT_W-1:0]     cpos_q;
  logic [CNT_W-1:0]     p_q;
  slot_t                k_q;
  slot_t                h_q;
  slot_t                c_q;
  logic                 restart_q;
  logic                 hb_q;
  logic                 cb_q;
  value_t               mn_q;
  value_t               mx_q;
  logic [31:0]          min_range_q;
  logic [31:0]          rng_q;
  logic                 out_valid_q;
  out_item_t            out_q;

  slot_t                ord_mem [MAX_POINTS];
  slot_t                ord_rd_q;
  logic [ID_W-1:0]      id_mem [MAX_POINTS];
  logic [ID_W-1:0]      id_rd_q;

  logic                 in_acc;
  logic                 store;
  logic                 out_acc;
  logic [31:0]          r_w;
  lane_ctrl_t           lane_ctrl;
  value_t               lane_wdata [NUM_ATTRS];
  value_t               lane_rd [NUM_ATTRS];
  lane_flag_t           lane_flag [NUM_ATTRS];
  merge_res_t           mres;
  logic                 ord_we;
  slot_t                ord_waddr;
  slot_t                ord_wdata;
  logic                 ord_re;
  slot_t                ord_raddr;
  logic                 id_re;
  slot_t                id_raddr;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign store       = in_acc && (count_q < CNT_W'(MAX_POINTS));
  assign out_acc     = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign r_w         = 32'(mx_q - mn_q);

  assign lane_wdata[0] = in_item_i.attr_0;
  assign lane_wdata[1] = in_item_i.attr_1;
  assign lane_wdata[2] = in_item_i.attr_2;
  assign lane_wdata[3] = in_item_i.attr_3;
  assign lane_wdata[4] = in_item_i.attr_4;
  assign lane_wdata[5] = in_item_i.attr_5;
  assign lane_wdata[6] = in_item_i.attr_6;
  assign lane_wdata[7] = in_item_i.attr_7;

  for (genvar g = 0; g < NUM_ATTRS; g++) begin : g_lane
    sps_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (mask_q[g]),
      .ctrl_i (lane_ctrl),
      .wdata_i(lane_wdata[g]),
      .rd_o   (lane_rd[g]),
      .flag_o (lane_flag[g])
    );
  end

  sps_merge u_merge (
    .rd_i  (lane_rd),
    .mask_i(mask_q),
    .flag_i(lane_flag),
    .res_o (mres)
  );

  // memory and lane control per state
  always_comb begin
    lane_ctrl = '0;
    ord_we    = 1'b0;
    ord_waddr = count_q[SLOT_W-1:0];
    ord_wdata = count_q[SLOT_W-1:0];
    ord_re    = 1'b0;
    ord_raddr = cpos_q[SLOT_W-1:0];
    id_re     = 1'b0;
    id_raddr  = h_q;
    lane_ctrl.addr = count_q[SLOT_W-1:0];
    case (state_q)
      ST_IDLE: begin
        lane_ctrl.we = store;
        ord_we       = store;
      end
      ST_INIT_RD: begin
        lane_ctrl.re   = 1'b1;
        lane_ctrl.addr = '0;
      end
      ST_INIT_CAP: begin
        lane_ctrl.head_ld_rd = 1'b1;
      end
      ST_LOOP: begin
        ord_re = 1'b1;
      end
      ST_C_ORD, ST_SC_ORD: begin
        lane_ctrl.re   = 1'b1;
        lane_ctrl.addr = ord_rd_q;
      end
      ST_C_CMP: begin
        lane_ctrl.cand_ld = 1'b1;
      end
      ST_C_DEC: begin
        lane_ctrl.head_ld_cand = !hb_q && cb_q;
      end
      ST_SC_CHK: begin
        ord_re    = (p_q < cpos_q);
        ord_raddr = p_q[SLOT_W-1:0];
        if (p_q >= cpos_q) begin
          lane_ctrl.head_ld_cand = 1'b1;
          ord_we    = 1'b1;
          ord_waddr = cpos_q[SLOT_W-1:0];
          ord_wdata = h_q;
        end
      end
      ST_RM_RD: begin
        ord_re    = 1'b1;
        ord_raddr = tail_q;
      end
      ST_RM_WR: begin
        ord_we    = 1'b1;
        ord_waddr = cpos_q[SLOT_W-1:0];
        ord_wdata = ord_rd_q;
      end
      ST_E_ORD: begin
        ord_re    = (k_q != '0);
        ord_raddr = k_q;
        id_re     = (k_q == '0);
        id_raddr  = h_q;
      end
      ST_E_ORD2: begin
        id_re    = 1'b1;
        id_raddr = ord_rd_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    if (ord_re) begin
      ord_rd_q <= ord_mem[ord_raddr];
    end
    if (store) begin
      id_mem[count_q[SLOT_W-1:0]] <= in_item_i.point_id;
    end
    if (id_re) begin
      id_rd_q <= id_mem[id_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      mask_q      <= 8'hFF;
      tail_q      <= '0;
      cpos_q      <= CNT_W'(1);
      p_q         <= '0;
      k_q         <= '0;
      h_q         <= '0;
      c_q         <= '0;
      restart_q   <= 1'b0;
      hb_q        <= 1'b0;
      cb_q        <= 1'b0;
      mn_q        <= '0;
      mx_q        <= '0;
      min_range_q <= '0;
      rng_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
      if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (store) begin
              count_q <= count_q + CNT_W'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (in_item_i.last_point) begin
              tail_q  <= store ? count_q[SLOT_W-1:0] : SLOT_W'(MAX_POINTS - 1);
              cpos_q  <= CNT_W'(1);
              h_q     <= '0;
              state_q <= ST_INIT_RD;
            end
          end
        end
        ST_INIT_RD: state_q <= ST_INIT_CAP;
        ST_INIT_CAP: begin
          mn_q    <= mres.mn;
          mx_q    <= mres.mx;
          state_q <= ST_INIT_RNG;
        end
        ST_INIT_RNG: begin
          min_range_q <= r_w;
          state_q     <= ST_LOOP;
        end
        ST_LOOP: begin
          state_q <= (cpos_q <= {1'b0, tail_q}) ? ST_C_ORD : ST_E_ORD;
          k_q     <= '0;
        end
        ST_C_ORD: begin
          c_q     <= ord_rd_q;
          state_q <= ST_C_CMP;
        end
        ST_C_CMP: begin
          hb_q    <= mres.head_better;
          cb_q    <= mres.cand_better;
          mn_q    <= mres.mn;
          mx_q    <= mres.mx;
          state_q <= ST_C_DEC;
        end
        ST_C_DEC: begin
          if (hb_q && !cb_q) begin
            state_q <= ST_RM_RD;
          end else if (!hb_q && cb_q) begin
            h_q         <= c_q;
            min_range_q <= r_w;
            restart_q   <= 1'b1;
            state_q     <= ST_RM_RD;
          end else if (r_w < min_range_q) begin
            rng_q   <= r_w;
            p_q     <= CNT_W'(1);
            state_q <= ST_SC_CHK;
          end else begin
            cpos_q  <= cpos_q + CNT_W'(1);
            state_q <= ST_LOOP;
          end
        end
        ST_SC_CHK: begin
          if (p_q < cpos_q) begin
            state_q <= ST_SC_ORD;
          end else begin
            // no earlier point covers the candidate: swap it to the head
            h_q         <= c_q;
            min_range_q <= rng_q;
            cpos_q      <= cpos_q + CNT_W'(1);
            state_q     <= ST_LOOP;
          end
        end
        ST_SC_ORD: state_q <= ST_SC_CMP;
        ST_SC_CMP: begin
          if (mres.covered) begin
            state_q <= ST_RM_RD;
          end else begin
            p_q     <= p_q + CNT_W'(1);
            state_q <= ST_SC_CHK;
          end
        end
        ST_RM_RD: state_q <= ST_RM_WR;
        ST_RM_WR: begin
          tail_q <= tail_q - SLOT_W'(1);
          if (restart_q) begin
            cpos_q    <= CNT_W'(1);
            restart_q <= 1'b0;
          end
          state_q <= ST_LOOP;
        end
        ST_E_ORD: state_q <= (k_q == '0) ? ST_E_ID : ST_E_ORD2;
        ST_E_ORD2: state_q <= ST_E_ID;
        ST_E_ID: begin
          out_q.survivor_id <= id_rd_q;
          out_q.is_pivot    <= (k_q == '0);
          out_q.pivot_range <= min_range_q;
          out_q.overflow    <= ovf_q;
          out_q.last_result <= (k_q == tail_q);
          out_valid_q       <= 1'b1;
          state_q           <= ST_E_WAIT;
        end
        ST_E_WAIT: begin
          if (out_acc) begin
            if (k_q == tail_q) begin
              count_q <= '0;
              ovf_q   <= 1'b0;
              state_q <= ST_IDLE;
            end else begin
              k_q     <= k_q + SLOT_W'(1);
              state_q <= ST_E_ORD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `SPS_ASSERT_NOW(a_no_in_while_out, out_valid_q, !in_ready_o, "input open during output")
  `SPS_ASSERT_NOW(a_pivot_first, out_valid_q && out_q.is_pivot, k_q == '0, "pivot not first")
  `SPS_ASSERT_NOW(a_cpos_nonzero, state_q != ST_IDLE, cpos_q != '0, "scan position zero")
  `SPS_ASSERT_NEXT(a_last_to_idle, out_acc && out_q.last_result, in_ready_o, "no idle after batch")

endmodule

// File: test/skyline_pivot_select_tb.sv
// ----------------------------------------------------------------------------
// skyline_pivot_select_tb
// Self-checking bench: loads point batches, predicts the pivot selection over
// the enabled attribute subspace and compares every survivor transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skyline_pivot_select_tb;
  import sps_pkg::*;

  localparam int WATCHDOG = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_item_o;
  logic cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = 8'hFF;

  skyline_pivot_select dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic signed [31:0] pt_attr [MAX_POINTS][NUM_ATTRS];
  logic [15:0] pt_id [MAX_POINTS];
  int unsigned pt_count;
  bit pt_ovf;
  logic [7:0] subspace;
  out_item_t survivors_q[$];

  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  function automatic logic [31:0] range_of(int s);
    logic signed [31:0] hi, lo;
    bit any;
    any = 0; hi = 0; lo = 0;
    for (int a = 0; a < NUM_ATTRS; a++) begin
      if (subspace[a]) begin
        if (!any) begin
          hi = pt_attr[s][a]; lo = pt_attr[s][a]; any = 1;
        end else if (pt_attr[s][a] > hi) hi = pt_attr[s][a];
        else if (pt_attr[s][a] < lo) lo = pt_attr[s][a];
      end
    end
    return 32'(longint'(hi) - longint'(lo));
  endfunction

  function automatic bit can_lead(int ord[MAX_POINTS], int pos);
    bit cov;
    for (int p = 1; p < pos; p++) begin
      cov = 1;
      for (int a = 0; a < NUM_ATTRS; a++)
        if (subspace[a] && pt_attr[ord[pos]][a] < pt_attr[ord[p]][a]) cov = 0;
      if (cov) return 0;
    end
    return 1;
  endfunction

  task automatic select_pivot();
    int ord[MAX_POINTS];
    int tail, cpos, c, h, n, t;
    bit hb, cb;
    logic [31:0] min_r, r;
    out_item_t o;
    n = pt_count;
    if (n >= 1) begin
      for (int i = 0; i < n; i++) ord[i] = i;
      tail = n - 1; cpos = 1;
      min_r = range_of(ord[0]);
      while (cpos <= tail) begin
        c = ord[cpos]; h = ord[0]; hb = 0; cb = 0;
        for (int a = 0; a < NUM_ATTRS; a++) begin
          if (subspace[a]) begin
            if (pt_attr[h][a] < pt_attr[c][a]) hb = 1;
            else if (pt_attr[h][a] > pt_attr[c][a]) cb = 1;
          end
        end
        if (hb && !cb) begin
          ord[cpos] = ord[tail]; tail--;
        end else if (!hb && cb) begin
          ord[0] = ord[cpos]; ord[cpos] = ord[tail]; tail--;
          min_r = range_of(ord[0]); cpos = 1;
        end else begin
          r = range_of(c);
          if (r < min_r) begin
            if (can_lead(ord, cpos)) begin
              t = ord[0]; ord[0] = ord[cpos]; ord[cpos] = t;
              min_r = r; cpos++;
            end else begin
              ord[cpos] = ord[tail]; tail--;
            end
          end else cpos++;
        end
      end
      for (int k = 0; k <= tail; k++) begin
        o.survivor_id = pt_id[ord[k]];
        o.is_pivot = (k == 0);
        o.pivot_range = min_r;
        o.overflow = pt_ovf;
        o.last_result = (k == tail);
        survivors_q.push_back(o);
      end
    end
    pt_count = 0;
    pt_ovf = 0;
  endtask

  task automatic load_point(in_item_t it);
    logic signed [31:0] v [NUM_ATTRS];
    v = '{it.attr_0, it.attr_1, it.attr_2, it.attr_3,
          it.attr_4, it.attr_5, it.attr_6, it.attr_7};
    if (pt_count < MAX_POINTS) begin
      pt_id[pt_count] = it.point_id;
      for (int a = 0; a < NUM_ATTRS; a++) pt_attr[pt_count][a] = v[a];
      pt_count++;
    end else pt_ovf = 1;
    if (it.last_point) select_pivot();
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // shared driver: offer one point, predict on acceptance; valid drops only
  // for a gap or when the sender goes idle
  task automatic send_point(in_item_t it, bit gaps = 1);
    int g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    load_point(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (survivors_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_mask(logic [7:0] m);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    subspace = m;
  endtask

  function automatic logic signed [31:0] rand_attr(int mode);
    case (mode)
      0: return $signed($urandom_range(0, 7)) - 3;
      1: return $signed($urandom_range(0, 40)) - 20;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic in_item_t rand_point(int mode, bit last);
    in_item_t it;
    it.point_id = 16'($urandom());
    it.attr_0 = rand_attr(mode); it.attr_1 = rand_attr(mode);
    it.attr_2 = rand_attr(mode); it.attr_3 = rand_attr(mode);
    it.attr_4 = rand_attr(mode); it.attr_5 = rand_attr(mode);
    it.attr_6 = rand_attr(mode); it.attr_7 = rand_attr(mode);
    it.last_point = last;
    return it;
  endfunction

  task automatic send_batch(int n, int mode);
    for (int i = 0; i < n; i++) send_point(rand_point(mode, i == n - 1));
  endtask

  function automatic in_item_t flat_point(logic [15:0] id, logic signed [31:0] v, bit last);
    in_item_t it;
    it.point_id = id;
    it.attr_0 = v; it.attr_1 = v; it.attr_2 = v; it.attr_3 = v;
    it.attr_4 = v; it.attr_5 = v; it.attr_6 = v; it.attr_7 = v;
    it.last_point = last;
    return it;
  endfunction

  task automatic test_directed();
    in_item_t it;
    // single point, extremes of id and values
    send_point(flat_point(16'hFFFF, 32'sh7FFFFFFF, 1));
    send_point(flat_point(16'h0000, 32'sh80000000, 1));
    // full range spread: range hits the 32-bit maximum
    it = flat_point(16'h1234, 32'sh80000000, 0);
    it.attr_3 = 32'sh7FFFFFFF;
    send_point(it);
    // incomparable point with a smaller range, then one dominating the new head
    send_point(flat_point(16'h0002, 5, 0));
    send_point(flat_point(16'h0003, -9, 0));
    // incomparable, larger range
    it = flat_point(16'h0004, 0, 0);
    it.attr_0 = -100;
    send_point(it);
    // equal points
    send_point(flat_point(16'h0005, 1, 0));
    send_point(flat_point(16'h0006, 1, 1));
    write_mask(8'h01);
    send_batch(5, 1);
    write_mask(8'h00);  // empty subspace: all survive
    send_batch(4, 1);
  endtask

  task automatic test_overflow();
    write_mask(8'hFF);
    for (int i = 0; i < MAX_POINTS + 3; i++)
      send_point(rand_point(0, i == MAX_POINTS + 2), 0);
    // last point exactly at capacity + 1
    for (int i = 0; i <= MAX_POINTS; i++)
      send_point(rand_point(0, i == MAX_POINTS), 0);
  endtask

  task automatic test_backpressure();
    write_mask(8'h0F);
    // receiver stalls while batches keep coming
    hold_off = 1'b1;
    for (int b = 0; b < 3; b++) send_batch(6, 0);
    hold_off = 1'b0;
    drain();
  endtask

  task automatic test_random();
    int sent;
    logic [7:0] masks [5] = '{8'hFF, 8'h01, 8'h80, 8'h5A, 8'h03};
    sent = 0;
    while (sent < 290) begin
      int n;
      if ($urandom_range(0, 3) == 0) write_mask(masks[$urandom_range(0, 4)]);
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 10);
      send_batch(n, $urandom_range(0, 2));
      sent += n;
    end
  endtask

  // result checker: compares each accepted survivor with the prediction
  always @(posedge clk_i) begin
    out_item_t e;
    if (out_valid_o && out_ready_i) begin
      if (survivors_q.size() == 0) begin
        $error("unexpected survivor transaction id=%0h", out_item_o.survivor_id);
        errors++;
      end else begin
        e = survivors_q.pop_front();
        if (out_item_o.survivor_id !== e.survivor_id) begin
          $error("survivor_id exp %0h got %0h", e.survivor_id, out_item_o.survivor_id);
          errors++;
        end
        if (out_item_o.is_pivot !== e.is_pivot) begin
          $error("is_pivot exp %0b got %0b", e.is_pivot, out_item_o.is_pivot);
          errors++;
        end
        if (out_item_o.pivot_range !== e.pivot_range) begin
          $error("pivot_range exp %0h got %0h", e.pivot_range, out_item_o.pivot_range);
          errors++;
        end
        if (out_item_o.overflow !== e.overflow) begin
          $error("overflow exp %0b got %0b", e.overflow, out_item_o.overflow);
          errors++;
        end
        if (out_item_o.last_result !== e.last_result) begin
          $error("last_result exp %0b got %0b", e.last_result, out_item_o.last_result);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, long hold-off when requested
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        out_ready_i <= 1'b1;
        @(posedge clk_i);
        wait (!hold_off);
      end
      g = gap_len();
      if (g != 0) begin
        out_ready_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("skyline_pivot_select_tb NOT OK");
      $finish;
    end
  end

  initial begin
    subspace = 8'hFF;
    pt_count = 0;
    pt_ovf = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0) $display("skyline_pivot_select_tb OK");
    else $display("skyline_pivot_select_tb NOT OK");
    $finish;
  end

endmodule
